[design/fdpe_pkg.sv]
// Shared types, codes and constants for the fractional divider parameter encoder.
// No dependencies; every other design file imports this package.
package fdpe_pkg;

  localparam int FRAC_BITS_DEF  = 20;
  localparam int FIELD_W        = 20;
  localparam int INT_W          = 12;
  localparam int P1_W           = 18;
  localparam int BYTES_W        = 64;
  localparam int CTRL_W         = 8;
  localparam int PRESCALE_SHIFT = 7;
  localparam int P1_OFFSET      = 512;
  localparam int P1_MAX         = 262143;
  localparam int PLL_INT_MIN    = 15;
  localparam int PLL_INT_MAX    = 90;
  localparam int OUT_INT_MIN    = 3;
  localparam int OUT_INT_MAX    = 2049;

  localparam logic [CTRL_W-1:0] CTRL_BASE = 8'h0F;
  localparam int CTRL_PHASE_BIT = 4;
  localparam int CTRL_PLLB_BIT  = 5;
  localparam int CTRL_INT_BIT   = 6;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 136;

  typedef enum logic {
    CMD_PLL = 1'b0,
    CMD_OUT = 1'b1
  } fdpe_cmd_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_INT_RANGE = 2'd1,
    ERR_ZERO_DEN  = 2'd2,
    ERR_P1_RANGE  = 2'd3
  } fdpe_err_e;

  typedef struct packed {
    logic [INT_W-1:0]   a;
    fdpe_cmd_e          mode;
    logic               pll_b;
    logic               phase;
    logic               b_zero;
    fdpe_err_e          err;
    logic [FIELD_W-1:0] den;
  } fdpe_side_t;

  typedef struct packed {
    logic [P1_W-1:0]    p1;
    logic [FIELD_W-1:0] p2;
    logic [FIELD_W-1:0] p3;
    logic [BYTES_W-1:0] bytes;
    logic [CTRL_W-1:0]  ctrl;
    fdpe_err_e          err;
  } fdpe_result_t;

endpackage

[design/fractional_divider_param_encoder_top.sv]
// Throughput: one word per cycle unless the skid register holds a word; the quotient is
// retired one bit per stage across FRAC_BITS + 7 divider stages, followed by a pack
// stage and an output register with skid.
// Reset: asynchronous, active low; clears all valid bits, payload registers are not reset.
// Top level of the fractional divider parameter encoder; depends on fdpe_pkg,
// fdpe_front, fdpe_div_step and fdpe_pack.
module fractional_divider_param_encoder_top
  import fdpe_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // integer_part, frac_numerator, frac_denominator, source_pll, phase_enable, zero fill
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // cmd
  input  logic [0:0]             s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // param_one, param_two, param_three, register_bytes, clock_control, error_code, zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int DIV_W = FRAC_BITS + PRESCALE_SHIFT;

  logic                 en;
  logic                 vld_w  [DIV_W+1];
  logic [DIV_W-1:0]     num_w  [DIV_W+1];
  logic [FRAC_BITS-1:0] rem_w  [DIV_W+1];
  fdpe_side_t           side_w [DIV_W+1];
  logic                 tail_vld;
  fdpe_result_t         tail_res;
  logic                 out_v_q;
  logic                 skid_v_q;
  fdpe_result_t         out_q;
  fdpe_result_t         skid_q;
  logic                 tail_take;
  logic                 out_free;

  assign en              = !skid_v_q;
  assign s_axis_tready_o = en;

  fdpe_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .cmd_i   (s_axis_tuser_i[0]),
    .int_i   (s_axis_tdata_i[11:0]),
    .num_i   (s_axis_tdata_i[31:12]),
    .den_i   (s_axis_tdata_i[51:32]),
    .pll_b_i (s_axis_tdata_i[52]),
    .phase_i (s_axis_tdata_i[53]),
    .valid_o (vld_w[0]),
    .num_o   (num_w[0]),
    .rem_o   (rem_w[0]),
    .side_o  (side_w[0])
  );

  for (genvar i = 0; i < DIV_W; i++) begin : g_div
    fdpe_div_step #(.FRAC_BITS(FRAC_BITS)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld_w[i]),
      .num_i   (num_w[i]),
      .rem_i   (rem_w[i]),
      .side_i  (side_w[i]),
      .valid_o (vld_w[i+1]),
      .num_o   (num_w[i+1]),
      .rem_o   (rem_w[i+1]),
      .side_o  (side_w[i+1])
    );
  end

  fdpe_pack #(.FRAC_BITS(FRAC_BITS)) u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld_w[DIV_W]),
    .quo_i   (num_w[DIV_W]),
    .rem_i   (rem_w[DIV_W]),
    .side_i  (side_w[DIV_W]),
    .valid_o (tail_vld),
    .res_o   (tail_res)
  );

  assign tail_take = tail_vld && en;
  assign out_free  = !out_v_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q  <= skid_v_q || tail_take;
      skid_v_q <= 1'b0;
    end else if (tail_take) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_v_q ? skid_q : tail_res;
    end else if (tail_take) begin
      skid_q <= tail_res;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {4'b0, out_q.err, out_q.ctrl, out_q.bytes,
                            out_q.p3, out_q.p2, out_q.p1};

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid word held without output word");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !m_axis_tready_i |=> skid_v_q) else $error("skid word dropped");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.err != ERR_NONE |->
      out_q.p1 == '0 && out_q.p3 == '0 && out_q.bytes == '0 && out_q.ctrl == '0)
    else $error("error word carries payload");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.err == ERR_NONE |-> out_q.p3 != '0 && out_q.p2 < out_q.p3)
    else $error("remainder not below denominator");

endmodule

[design/fdpe_front.sv]
// Input stage: range check, zero-denominator check, operand masking.
// Depends on fdpe_pkg.
module fdpe_front
  import fdpe_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int DIV_W = FRAC_BITS + PRESCALE_SHIFT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic               cmd_i,
  input  logic [INT_W-1:0]   int_i,
  input  logic [FIELD_W-1:0] num_i,
  input  logic [FIELD_W-1:0] den_i,
  input  logic               pll_b_i,
  input  logic               phase_i,
  output logic               valid_o,
  output logic [DIV_W-1:0]   num_o,
  output logic [FRAC_BITS-1:0] rem_o,
  output fdpe_side_t         side_o
);

  logic [FRAC_BITS-1:0] b_m;
  logic [FRAC_BITS-1:0] c_m;
  logic                 in_range;
  fdpe_cmd_e            mode;
  fdpe_side_t           side_d;
  logic                 valid_q;
  logic [DIV_W-1:0]     num_q;
  fdpe_side_t           side_q;

  always_comb begin
    b_m  = num_i[FRAC_BITS-1:0];
    c_m  = den_i[FRAC_BITS-1:0];
    mode = fdpe_cmd_e'(cmd_i);
    if (mode == CMD_PLL) begin
      in_range = (int_i >= INT_W'(PLL_INT_MIN)) && (int_i <= INT_W'(PLL_INT_MAX));
    end else begin
      in_range = (int_i >= INT_W'(OUT_INT_MIN)) && (int_i <= INT_W'(OUT_INT_MAX));
    end
    side_d.a      = int_i;
    side_d.mode   = mode;
    side_d.pll_b  = pll_b_i;
    side_d.phase  = phase_i;
    side_d.b_zero = (b_m == '0);
    side_d.den    = FIELD_W'(c_m);
    if (!in_range) begin
      side_d.err = ERR_INT_RANGE;
    end else if (c_m == '0) begin
      side_d.err = ERR_ZERO_DEN;
    end else begin
      side_d.err = ERR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= {b_m, PRESCALE_SHIFT'(0)};
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign num_o   = num_q;
  assign rem_o   = '0;
  assign side_o  = side_q;

endmodule

[design/fdpe_div_step.sv]
// One restoring-division stage: retires one quotient bit per register stage.
// Depends on fdpe_pkg.
module fdpe_div_step
  import fdpe_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int DIV_W = FRAC_BITS + PRESCALE_SHIFT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [DIV_W-1:0]     num_i,
  input  logic [FRAC_BITS-1:0] rem_i,
  input  fdpe_side_t           side_i,
  output logic                 valid_o,
  output logic [DIV_W-1:0]     num_o,
  output logic [FRAC_BITS-1:0] rem_o,
  output fdpe_side_t           side_o
);

  logic [FRAC_BITS:0]   trial;
  logic [FRAC_BITS:0]   den_ext;
  logic                 ge;
  logic [FRAC_BITS-1:0] rem_d;
  logic [DIV_W-1:0]     num_d;
  logic                 valid_q;
  logic [DIV_W-1:0]     num_q;
  logic [FRAC_BITS-1:0] rem_q;
  fdpe_side_t           side_q;

  always_comb begin
    trial   = {rem_i, num_i[DIV_W-1]};
    den_ext = {1'b0, side_i.den[FRAC_BITS-1:0]};
    ge      = (trial >= den_ext);
    rem_d   = ge ? FRAC_BITS'(trial - den_ext) : trial[FRAC_BITS-1:0];
    num_d   = {num_i[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= num_d;
      rem_q  <= rem_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign num_o   = num_q;
  assign rem_o   = rem_q;
  assign side_o  = side_q;

endmodule

[design/fdpe_pack.sv]
// Final stage: P1 offset and range check, register byte packing, clock control.
// Depends on fdpe_pkg.
module fdpe_pack
  import fdpe_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int DIV_W = FRAC_BITS + PRESCALE_SHIFT,
  localparam int SUM_W = ((DIV_W > P1_W + 1) ? DIV_W : P1_W + 1) + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [DIV_W-1:0]     quo_i,
  input  logic [FRAC_BITS-1:0] rem_i,
  input  fdpe_side_t           side_i,
  output logic                 valid_o,
  output fdpe_result_t         res_o
);

  logic [SUM_W-1:0] sum;
  logic             p1_bad;
  logic [P1_W-1:0]  p1;
  logic [FIELD_W-1:0] p2;
  logic [FIELD_W-1:0] p3;
  fdpe_result_t     res_d;
  logic             valid_q;
  fdpe_result_t     res_q;

  always_comb begin
    sum    = {{(SUM_W-INT_W-PRESCALE_SHIFT){1'b0}}, side_i.a, PRESCALE_SHIFT'(0)}
           + SUM_W'(quo_i);
    p1_bad = (sum < SUM_W'(P1_OFFSET)) || (sum > SUM_W'(P1_MAX + P1_OFFSET));
    p1     = P1_W'(sum - SUM_W'(P1_OFFSET));
    p2     = FIELD_W'(rem_i);
    p3     = side_i.den;
    res_d  = '0;
    if (side_i.err != ERR_NONE) begin
      res_d.err = side_i.err;
    end else if (p1_bad) begin
      res_d.err = ERR_P1_RANGE;
    end else begin
      res_d.err   = ERR_NONE;
      res_d.p1    = p1;
      res_d.p2    = p2;
      res_d.p3    = p3;
      res_d.bytes = {p3[15:8], p3[7:0], 6'b0, p1[17:16], p1[15:8], p1[7:0],
                     p3[19:16], p2[19:16], p2[15:8], p2[7:0]};
      if (side_i.mode == CMD_OUT) begin
        res_d.ctrl                 = CTRL_BASE;
        res_d.ctrl[CTRL_PHASE_BIT] = side_i.phase;
        res_d.ctrl[CTRL_PLLB_BIT]  = side_i.pll_b;
        res_d.ctrl[CTRL_INT_BIT]   = side_i.b_zero && !side_i.phase;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
